### hdl/msr_pkg.sv
// Shared types and constants for the motor speed ramp with reversal.
package msr_pkg;

	localparam int SPEED_W = 8;
	localparam int TICK_W  = 16;
	localparam int PWM_W   = 16;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [TICK_W-1:0] TICKS_RESET = 16'd12;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_FWD  = 2'd1,
		OP_BWD  = 2'd2,
		OP_STOP = 2'd3
	} op_t;

	typedef enum logic {
		REG_TICKS_PER_STEP = 1'b0
	} reg_idx_t;

	typedef struct packed {
		op_t                op;
		logic [SPEED_W-1:0] target;
	} item_t;

	typedef struct packed {
		logic [PWM_W-1:0]   pwm;
		logic               fwd;
		logic               bwd;
		logic [SPEED_W-1:0] speed;
		logic               ramping;
	} result_t;

endpackage

### hdl/motor_speed_ramp_reversal.sv
// Top level of the soft-start motor speed ramp with direction reversal.
// Usage:
//   Item channel: item_valid, item_stall, opcode, target_speed. A beat is
//   taken at a rising edge with item_valid high and item_stall low.
//   Opcodes: tick, forward, backward, stop.
//   Result channel: result_valid, result_stall, pwm_level, forward_drive,
//   backward_drive, speed_now, ramping. Every item yields exactly one beat.
//   Path: a taken item enters the input register, then the result register.
//   Throughput: one item per cycle unless result_stall holds it; the ramp
//   state updates as an item moves from the input to the result register.
//   Receiver stall: the result register holds; the input register holds
//   its item and item_stall rises until the result register frees up.
//   Reset: speed, goal, pins and tick counter clear, direction is forward,
//   both stages empty, ticks_per_step returns to 12.
//   APB register at byte address 0: ticks_per_step (16 bits, 0 acts as 1).
//   Write it only while no item is in flight.
module motor_speed_ramp_reversal (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [msr_pkg::ADDR_W-1:0]    paddr,
	input  logic [msr_pkg::DATA_W-1:0]    pwdata,
	output logic [msr_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    opcode,
	input  logic [msr_pkg::SPEED_W-1:0]   target_speed,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [msr_pkg::PWM_W-1:0]     pwm_level,
	output logic                          forward_drive,
	output logic                          backward_drive,
	output logic [msr_pkg::SPEED_W-1:0]   speed_now,
	output logic                          ramping
);

	logic [msr_pkg::TICK_W-1:0] ticks_per_step;
	logic                       valid_s1;
	msr_pkg::item_t             item_s1;
	logic                       free;
	logic                       advance;
	msr_pkg::result_t           result_d;
	msr_pkg::result_t           result_q;

	assign advance    = valid_s1 && free;
	assign item_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1.op     <= msr_pkg::op_t'(opcode);
			item_s1.target <= target_speed;
		end
	end

	msr_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.ticks_per_step (ticks_per_step)
	);

	msr_ramp u_ramp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ticks_per_step (ticks_per_step),
		.advance        (advance),
		.item           (item_s1),
		.result         (result_d)
	);

	msr_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (valid_s1),
		.result_d     (result_d),
		.result_stall (result_stall),
		.free         (free),
		.result_valid (result_valid),
		.result_q     (result_q)
	);

	assign pwm_level      = result_q.pwm;
	assign forward_drive  = result_q.fwd;
	assign backward_drive = result_q.bwd;
	assign speed_now      = result_q.speed;
	assign ramping        = result_q.ramping;

endmodule

### hdl/msr_cfg.sv
// Configuration register file: step length in ticks.
module msr_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [msr_pkg::ADDR_W-1:0]   paddr,
	input  logic [msr_pkg::DATA_W-1:0]   pwdata,
	output logic [msr_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output logic [msr_pkg::TICK_W-1:0]   ticks_per_step
);

	logic [msr_pkg::TICK_W-1:0] ticks_q;
	msr_pkg::reg_idx_t          idx;
	logic                       wr_en;

	assign idx   = msr_pkg::reg_idx_t'(paddr[msr_pkg::ADDR_W-1]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= msr_pkg::TICKS_RESET;
		end else if (wr_en && idx == msr_pkg::REG_TICKS_PER_STEP) begin
			ticks_q <= pwdata[msr_pkg::TICK_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			msr_pkg::REG_TICKS_PER_STEP: prdata[msr_pkg::TICK_W-1:0] = ticks_q;
			default:                     prdata = '0;
		endcase
	end

	assign pready         = 1'b1;
	assign ticks_per_step = ticks_q;

endmodule

### hdl/msr_ramp.sv
// Ramp state and its combinational update for one item.
module msr_ramp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [msr_pkg::TICK_W-1:0]  ticks_per_step,
	input  logic                        advance,
	input  msr_pkg::item_t              item,
	output msr_pkg::result_t            result
);

	localparam int SW = msr_pkg::SPEED_W;
	localparam int TW = msr_pkg::TICK_W;

	logic [SW-1:0] speed_q, goal_q;
	logic          dir_bwd_q, rev_q, pin_fwd_q, pin_bwd_q;
	logic [TW-1:0] tick_q;

	logic [SW-1:0] speed_d, goal_d;
	logic          dir_bwd_d, rev_d, pin_fwd_d, pin_bwd_d;
	logic [TW-1:0] tick_d;

	logic [SW-1:0] base_speed;
	logic          base_rev;
	logic          do_step;
	logic [SW-1:0] step_speed;
	logic          step_rev;

	logic          moving;
	logic [TW-1:0] limit;
	logic [TW-1:0] tick_inc;
	logic          want_bwd;
	logic          cmd_rev;

	assign moving   = rev_q || (speed_q != goal_q);
	assign limit    = (ticks_per_step == '0) ? TW'(1) : ticks_per_step;
	assign tick_inc = tick_q + TW'(1);
	assign want_bwd = (item.op == msr_pkg::OP_BWD);
	assign cmd_rev  = (speed_q != '0) && ((want_bwd != dir_bwd_q) || rev_q);

	always_comb begin
		step_speed = base_speed;
		step_rev   = base_rev;
		if (base_rev) begin
			if (base_speed != '0) begin
				step_speed = base_speed - SW'(1);
			end
			if (step_speed == '0) begin
				step_rev = 1'b0;
			end
		end else if (base_speed < goal_d) begin
			step_speed = base_speed + SW'(1);
		end else if (base_speed > goal_d) begin
			step_speed = base_speed - SW'(1);
		end
	end

	always_comb begin
		base_speed = speed_q;
		base_rev   = rev_q;
		do_step    = 1'b0;
		goal_d     = goal_q;
		dir_bwd_d  = dir_bwd_q;
		pin_fwd_d  = pin_fwd_q;
		pin_bwd_d  = pin_bwd_q;
		tick_d     = tick_q;
		case (item.op)
			msr_pkg::OP_TICK: begin
				if (moving) begin
					if (tick_inc >= limit) begin
						tick_d  = '0;
						do_step = 1'b1;
					end else begin
						tick_d = tick_inc;
					end
				end else begin
					tick_d = '0;
				end
			end
			msr_pkg::OP_FWD, msr_pkg::OP_BWD: begin
				pin_fwd_d = !want_bwd;
				pin_bwd_d = want_bwd;
				base_rev  = cmd_rev;
				dir_bwd_d = want_bwd;
				goal_d    = item.target;
				tick_d    = '0;
				do_step   = cmd_rev || (speed_q != item.target);
			end
			msr_pkg::OP_STOP: begin
				base_speed = '0;
				base_rev   = 1'b0;
				goal_d     = '0;
				dir_bwd_d  = 1'b0;
				pin_fwd_d  = 1'b0;
				pin_bwd_d  = 1'b0;
				tick_d     = '0;
			end
			default: begin
				tick_d = tick_q;
			end
		endcase
		speed_d = do_step ? step_speed : base_speed;
		rev_d   = do_step ? step_rev : base_rev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q   <= '0;
			goal_q    <= '0;
			dir_bwd_q <= 1'b0;
			rev_q     <= 1'b0;
			pin_fwd_q <= 1'b0;
			pin_bwd_q <= 1'b0;
			tick_q    <= '0;
		end else if (advance) begin
			speed_q   <= speed_d;
			goal_q    <= goal_d;
			dir_bwd_q <= dir_bwd_d;
			rev_q     <= rev_d;
			pin_fwd_q <= pin_fwd_d;
			pin_bwd_q <= pin_bwd_d;
			tick_q    <= tick_d;
		end
	end

	always_comb begin
		result.pwm     = msr_pkg::PWM_W'(speed_d) * msr_pkg::PWM_W'(speed_d);
		result.fwd     = pin_fwd_d;
		result.bwd     = pin_bwd_d;
		result.speed   = speed_d;
		result.ramping = rev_d || (speed_d != goal_d);
	end

endmodule

### hdl/msr_out.sv
// Result register with valid and stall toward the receiver.
module msr_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  msr_pkg::result_t result_d,
	input  logic             result_stall,
	output logic             free,
	output logic             result_valid,
	output msr_pkg::result_t result_q
);

	logic             valid_s2;
	msr_pkg::result_t data_s2;

	assign free = !valid_s2 || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_s2 <= result_d;
		end
	end

	assign result_valid = valid_s2;
	assign result_q     = data_s2;

endmodule

### dv/motor_speed_ramp_reversal_tb.sv
// Self-checking testbench for the motor speed ramp with direction reversal.
module motor_speed_ramp_reversal_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 3000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [msr_pkg::ADDR_W-1:0]   paddr = '0;
	logic [msr_pkg::DATA_W-1:0]   pwdata = '0;
	logic [msr_pkg::DATA_W-1:0]   prdata;
	logic                         pready;
	logic                         item_valid = 1'b0;
	logic                         item_stall;
	logic [1:0]                   opcode = msr_pkg::OP_TICK;
	logic [msr_pkg::SPEED_W-1:0]  target_speed = '0;
	logic                         result_valid;
	logic                         result_stall = 1'b0;
	logic [msr_pkg::PWM_W-1:0]    pwm_level;
	logic                         forward_drive;
	logic                         backward_drive;
	logic [msr_pkg::SPEED_W-1:0]  speed_now;
	logic                         ramping;

	motor_speed_ramp_reversal uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.opcode         (opcode),
		.target_speed   (target_speed),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.pwm_level      (pwm_level),
		.forward_drive  (forward_drive),
		.backward_drive (backward_drive),
		.speed_now      (speed_now),
		.ramping        (ramping)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [msr_pkg::SPEED_W-1:0] cur_speed = '0;
	logic [msr_pkg::SPEED_W-1:0] goal_speed = '0;
	logic                        going_back = 1'b0;
	logic                        in_reversal = 1'b0;
	logic                        pin_f = 1'b0;
	logic                        pin_b = 1'b0;
	logic [msr_pkg::TICK_W-1:0]  tick_cnt = '0;
	logic [msr_pkg::TICK_W-1:0]  step_len = msr_pkg::TICKS_RESET;

	msr_pkg::result_t drive_levels_due[$];
	int      level_mismatches = 0;
	int      quiet_cycles = 0;
	int      send_pct = 0;
	int      recv_pct = 0;
	int      hold_left = 0;

	function automatic logic ramp_active();
		return in_reversal || (cur_speed != goal_speed);
	endfunction

	function automatic void step_speed();
		if (in_reversal) begin
			if (cur_speed != 0)
				cur_speed = cur_speed - 1'b1;
			if (cur_speed == 0)
				in_reversal = 1'b0;
		end else if (cur_speed < goal_speed) begin
			cur_speed = cur_speed + 1'b1;
		end else if (cur_speed > goal_speed) begin
			cur_speed = cur_speed - 1'b1;
		end
	endfunction

	function automatic void steer(logic want_back, logic [msr_pkg::SPEED_W-1:0] tgt);
		pin_f = !want_back;
		pin_b = want_back;
		in_reversal = (cur_speed != 0) && ((want_back != going_back) || in_reversal);
		going_back = want_back;
		goal_speed = tgt;
		tick_cnt = '0;
		if (ramp_active())
			step_speed();
	endfunction

	function automatic msr_pkg::result_t ramp_predict(msr_pkg::op_t op,
		logic [msr_pkg::SPEED_W-1:0] tgt);
		msr_pkg::result_t r;
		logic [msr_pkg::TICK_W:0] lim;
		case (op)
			msr_pkg::OP_TICK: begin
				if (ramp_active()) begin
					lim = (step_len == 0) ? 17'd1 : {1'b0, step_len};
					tick_cnt = tick_cnt + 1'b1;
					if ({1'b0, tick_cnt} >= lim) begin
						tick_cnt = '0;
						step_speed();
					end
				end else begin
					tick_cnt = '0;
				end
			end
			msr_pkg::OP_FWD: steer(1'b0, tgt);
			msr_pkg::OP_BWD: steer(1'b1, tgt);
			default: begin
				cur_speed = '0;
				goal_speed = '0;
				going_back = 1'b0;
				in_reversal = 1'b0;
				pin_f = 1'b0;
				pin_b = 1'b0;
				tick_cnt = '0;
			end
		endcase
		r.pwm = {8'd0, cur_speed} * {8'd0, cur_speed};
		r.fwd = pin_f;
		r.bwd = pin_b;
		r.speed = cur_speed;
		r.ramping = ramp_active();
		return r;
	endfunction

	// hold the payload until the beat is taken
	task automatic send_item(msr_pkg::op_t op, logic [msr_pkg::SPEED_W-1:0] tgt);
		logic taken;
		while (send_pct != 0 && $urandom_range(99) < send_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		target_speed <= tgt;
		do begin
			@(negedge clk);
			taken = !item_stall;
			@(posedge clk);
		end while (!taken);
		drive_levels_due.push_back(ramp_predict(op, tgt));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (drive_levels_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_step(logic [msr_pkg::TICK_W-1:0] len);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {msr_pkg::REG_TICKS_PER_STEP, 2'b00};
		pwdata <= {16'd0, len};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		step_len = len;
		@(posedge clk);
	endtask

	task automatic set_idling(int s, int r);
		wait_drained();
		@(negedge clk);
		send_pct = s;
		recv_pct = r;
		@(posedge clk);
	endtask

	// command bursts: a forward, backward, stop or tick, then a run of up to 24 ticks
	task automatic run_ramps(int n_items);
		int   sent;
		int   pick;
		int   burst;
		msr_pkg::op_t op;
		logic [msr_pkg::SPEED_W-1:0] tgt;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 42)
				op = msr_pkg::OP_FWD;
			else if (pick < 84)
				op = msr_pkg::OP_BWD;
			else if (pick < 92)
				op = msr_pkg::OP_STOP;
			else
				op = msr_pkg::OP_TICK;
			pick = $urandom_range(9);
			if (pick < 5)
				tgt = 8'($urandom_range(0, 12));
			else if (pick == 9)
				tgt = 8'hFF;
			else
				tgt = 8'($urandom_range(0, 255));
			send_item(op, tgt);
			burst = $urandom_range(0, 24);
			repeat (burst) send_item(msr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
			sent += burst + 1;
			if ($urandom_range(15) == 0)
				wait_drained();
		end
	endtask

	task automatic test_directed_commands();
		send_item(msr_pkg::OP_TICK, 8'h00);
		send_item(msr_pkg::OP_FWD, 8'hFF);
		send_item(msr_pkg::OP_TICK, 8'hAA);
		send_item(msr_pkg::OP_FWD, 8'd10);
		send_item(msr_pkg::OP_BWD, 8'd200);
		send_item(msr_pkg::OP_FWD, 8'd0);
		send_item(msr_pkg::OP_BWD, 8'hFF);
		send_item(msr_pkg::OP_STOP, 8'h55);
		send_item(msr_pkg::OP_TICK, 8'hFF);
		send_item(msr_pkg::OP_BWD, 8'd0);
		send_item(msr_pkg::OP_FWD, 8'd1);
		wait_drained();
	endtask

	task automatic test_zero_step();
		set_step(16'd0);
		send_item(msr_pkg::OP_FWD, 8'd3);
		repeat (3) send_item(msr_pkg::OP_TICK, 8'd0);
		send_item(msr_pkg::OP_BWD, 8'd2);
		send_item(msr_pkg::OP_FWD, 8'd4);
		repeat (5) send_item(msr_pkg::OP_TICK, 8'hFF);
		send_item(msr_pkg::OP_STOP, 8'd0);
		wait_drained();
	endtask

	task automatic test_ramps_slow_receiver();
		set_idling(9, 55);
		set_step(16'd1);
		run_ramps(60);
		set_step(16'd3);
		run_ramps(60);
		set_step(16'd0);
		run_ramps(30);
	endtask

	task automatic test_ramps_slow_sender();
		set_idling(55, 9);
		set_step(16'd2);
		run_ramps(60);
		set_step(16'hFFFF);
		run_ramps(20);
		set_step(16'($urandom_range(1, 6)));
		run_ramps(60);
	endtask

	task automatic test_ramps_streaming();
		set_idling(0, 0);
		set_step(16'd1);
		run_ramps(60);
		set_step(16'($urandom_range(1, 20)));
		run_ramps(60);
	endtask

	// block the result side long enough for both stages to fill
	task automatic test_backpressure();
		set_idling(0, 0);
		set_step(16'd1);
		@(negedge clk);
		hold_left = 50;
		@(posedge clk);
		send_item(msr_pkg::OP_BWD, 8'd40);
		repeat (20) send_item(msr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
		send_item(msr_pkg::OP_FWD, 8'd5);
		repeat (8) send_item(msr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			result_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
		end
	end

	always @(negedge clk) begin
		msr_pkg::result_t got;
		msr_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			got.pwm = pwm_level;
			got.fwd = forward_drive;
			got.bwd = backward_drive;
			got.speed = speed_now;
			got.ramping = ramping;
			if (drive_levels_due.size() == 0) begin
				level_mismatches++;
				if (level_mismatches <= 10)
					$display("unexpected beat: pwm %0d fwd %b bwd %b speed %0d ramping %b",
						got.pwm, got.fwd, got.bwd, got.speed, got.ramping);
			end else begin
				want = drive_levels_due.pop_front();
				if (got.pwm !== want.pwm || got.fwd !== want.fwd || got.bwd !== want.bwd ||
					got.speed !== want.speed || got.ramping !== want.ramping) begin
					level_mismatches++;
					if (level_mismatches <= 10)
						$display("mismatch: exp pwm %0d fwd %b bwd %b speed %0d ramping %b, %s",
							want.pwm, want.fwd, want.bwd, want.speed, want.ramping,
							$sformatf("got pwm %0d fwd %b bwd %b speed %0d ramping %b",
								got.pwm, got.fwd, got.bwd, got.speed, got.ramping));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("motor_speed_ramp_reversal regression: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_commands();
		test_zero_step();
		test_ramps_slow_receiver();
		test_backpressure();
		test_ramps_slow_sender();
		test_ramps_streaming();
		wait_drained();
		repeat (4) @(posedge clk);
		if (level_mismatches == 0 && drive_levels_due.size() == 0)
			$display("motor_speed_ramp_reversal regression: pass");
		else
			$display("motor_speed_ramp_reversal regression: fail");
		$finish;
	end

endmodule
